### design/bb5_pkg.sv
// ----------------------------------------------------------------------------
// bb5_pkg: shared types and constants for the 5x5 box blur
// Pixel and row-sum packing, register indexes, and the divide by 25.
// ----------------------------------------------------------------------------
package bb5_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int MAX_HEIGHT    = 2048;
  localparam int RESET_WIDTH   = 1920;
  localparam int RESET_HEIGHT  = 1080;

  localparam int PIX_W   = 8;
  localparam int HSUM_W  = 11;
  localparam int VSUM_W  = 14;
  localparam int COORD_W = 11;
  localparam int DIM_W   = 12;
  localparam int SLOTS   = 4;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // (s + 12) / 25 as a multiply by reciprocal, exact for s below 6388
  localparam int DIV25_MUL   = 5243;
  localparam int DIV25_SHIFT = 17;
  localparam int DIV25_MUL_W = 13;
  localparam int ROUND_BIAS  = 12;

  typedef logic [PIX_W-1:0] chan_t;

  // red in the low bits
  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef struct packed {
    logic [HSUM_W-1:0] blue;
    logic [HSUM_W-1:0] green;
    logic [HSUM_W-1:0] red;
  } hsum_t;

  // horizontal sums of the last four rows for one column, slot = row mod 4
  typedef hsum_t [SLOTS-1:0] entry_t;

  function automatic chan_t div25(input logic [VSUM_W-1:0] s);
    logic [VSUM_W-1:0]             v;
    logic [VSUM_W+DIV25_MUL_W-1:0] p;
    v = s + VSUM_W'(ROUND_BIAS);
    p = {{DIV25_MUL_W{1'b0}}, v} * (VSUM_W + DIV25_MUL_W)'(DIV25_MUL);
    return p[DIV25_SHIFT +: PIX_W];
  endfunction

endpackage

### design/bb5_sum_store.sv
// ----------------------------------------------------------------------------
// bb5_sum_store: row-sum memory, one entry per column
// Synchronous read with forwarding of a same-cycle write.
// ----------------------------------------------------------------------------
module bb5_sum_store #(
  parameter int MAX_WIDTH = bb5_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic                         wr_en,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  bb5_pkg::entry_t              wr_data,
  output bb5_pkg::entry_t              rd_data
);

  bb5_pkg::entry_t mem [MAX_WIDTH];
  bb5_pkg::entry_t rd_q;
  bb5_pkg::entry_t fwd_data;
  logic            fwd_hit;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, held while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (en) begin
      rd_q     <= mem[rd_addr];
      fwd_data <= wr_data;
    end
  end

  // flag a read that collides with the write of the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (en) begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : rd_q;

endmodule

### design/rgb_box_blur_5x5_core.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_5x5_core: 5x5 edge-clamped box blur over an RGB raster stream
//
//   channel | handshake             | payload
//   --------+-----------------------+-------------------------------------
//   input   | in_valid / in_stall   | in_red, in_green, in_blue
//   output  | out_valid / out_stall | blur_*, out_col, out_row, last_of_run
//   config  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request per cycle inside the frame while in_stall is low. A request
// ending a row finishes up to 3 columns; on the last row each also finishes
// up to 3 rows, up to 9 results on the last pixel. The sequencer issues one
// row-sum memory read per unfrozen cycle and one write-back per column on its
// first row pass. Results pass the sequencer, memory read, sum and output
// registers. Reset is synchronous and needs no clearing pass. A skid register
// absorbs output stall, so in_stall depends only on registered state.
// ----------------------------------------------------------------------------
module rgb_box_blur_5x5_core #(
  parameter int MAX_WIDTH = bb5_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bb5_pkg::PIX_W-1:0]          in_red,
  input  logic [bb5_pkg::PIX_W-1:0]          in_green,
  input  logic [bb5_pkg::PIX_W-1:0]          in_blue,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bb5_pkg::PIX_W-1:0]          blur_red,
  output logic [bb5_pkg::PIX_W-1:0]          blur_green,
  output logic [bb5_pkg::PIX_W-1:0]          blur_blue,
  output logic [bb5_pkg::COORD_W-1:0]        out_col,
  output logic [bb5_pkg::COORD_W-1:0]        out_row,
  output logic                               last_of_run,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bb5_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bb5_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = bb5_pkg::COORD_W;
  localparam int RST_W = (bb5_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                            : bb5_pkg::RESET_WIDTH;

  typedef struct packed {
    bb5_pkg::chan_t              red;
    bb5_pkg::chan_t              green;
    bb5_pkg::chan_t              blue;
    logic [bb5_pkg::COORD_W-1:0] col;
    logic [bb5_pkg::COORD_W-1:0] row;
    logic                        last;
  } result_t;

  // configuration and position state
  logic [WID_W-1:0]          img_w;
  logic [bb5_pkg::DIM_W-1:0] img_h;
  logic [COL_W-1:0]          col_cnt;
  logic [ROW_W-1:0]          row_cnt;
  bb5_pkg::pixel_t           win [0:3];

  // sequencer stage
  logic             a_valid;
  bb5_pkg::pixel_t  a_pix [0:4];
  logic [COL_W-1:0] a_x;
  logic [ROW_W-1:0] a_y;
  logic [COL_W-1:0] a_c;
  logic [COL_W-1:0] a_c0;
  logic [COL_W-1:0] a_c1;
  logic [ROW_W-1:0] a_r;
  logic [ROW_W-1:0] a_r1;
  logic             a_emit;
  logic             a_first;
  logic             a_last;
  bb5_pkg::hsum_t   a_hs;

  // memory read stage
  logic             b_valid;
  logic             b_emit;
  logic             b_wr;
  logic             b_last;
  bb5_pkg::hsum_t   b_hs;
  logic [ROW_W-1:0] b_r;
  logic [ROW_W-1:0] b_y;
  logic [COL_W-1:0] b_c;
  bb5_pkg::entry_t  rd_entry;
  bb5_pkg::entry_t  wr_entry;
  logic             wr_en;

  // sum stage
  logic                        c_valid;
  logic [bb5_pkg::VSUM_W-1:0]  c_sum_r;
  logic [bb5_pkg::VSUM_W-1:0]  c_sum_g;
  logic [bb5_pkg::VSUM_W-1:0]  c_sum_b;
  logic [bb5_pkg::COORD_W-1:0] c_col;
  logic [bb5_pkg::COORD_W-1:0] c_row;
  logic                        c_last;
  logic [bb5_pkg::VSUM_W-1:0]  v_sum_r;
  logic [bb5_pkg::VSUM_W-1:0]  v_sum_g;
  logic [bb5_pkg::VSUM_W-1:0]  v_sum_b;

  // output and skid
  result_t res;
  result_t out_q;
  result_t skid;
  logic    skid_valid;
  logic    pipe_en;
  logic    out_take;

  // request decode
  logic                      in_acc;
  logic                      cfg_acc;
  bb5_pkg::pixel_t           pix_in;
  bb5_pkg::pixel_t           p_new [0:4];
  logic                      col_last;
  logic                      row_last;
  logic                      has_col;
  logic                      has_row;
  logic [COL_W-1:0]          c0;
  logic [COL_W-1:0]          c1;
  logic [ROW_W-1:0]          r0;
  logic [ROW_W-1:0]          r1;
  logic [WID_W-1:0]          cfg_w;
  logic [bb5_pkg::DIM_W-1:0] cfg_h;

  assign pipe_en   = !skid_valid;
  assign out_take  = out_valid && !out_stall;
  assign a_last    = (a_c == a_c1) && (!a_emit || (a_r == a_r1));
  assign in_stall  = !(pipe_en && (!a_valid || a_last));
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // clamp register writes into range
  always_comb begin
    if (cfg_data == '0) begin
      cfg_w = WID_W'(1);
      cfg_h = bb5_pkg::DIM_W'(1);
    end else begin
      cfg_w = (32'(cfg_data) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(cfg_data);
      cfg_h = (32'(cfg_data) > bb5_pkg::MAX_HEIGHT) ? bb5_pkg::DIM_W'(bb5_pkg::MAX_HEIGHT)
                                                     : bb5_pkg::DIM_W'(cfg_data);
    end
  end

  // window snapshot and the column and row ranges this request finishes
  always_comb begin
    pix_in   = '{blue: in_blue, green: in_green, red: in_red};
    p_new[4] = pix_in;
    for (int k = 0; k < 4; k++) begin
      p_new[3-k] = (col_cnt == '0) ? pix_in : win[k];
    end
    col_last = !((32'(col_cnt) + 32'd1) < 32'(img_w));
    row_last = !((32'(row_cnt) + 32'd1) < 32'(img_h));
    if (col_cnt >= COL_W'(2)) begin
      c0 = col_cnt - COL_W'(2);
    end else begin
      c0 = '0;
    end
    c1      = col_last ? col_cnt : c0;
    has_col = col_last || (col_cnt >= COL_W'(2));
    if (row_cnt >= ROW_W'(2)) begin
      r0 = row_cnt - ROW_W'(2);
    end else begin
      r0 = '0;
    end
    r1      = row_last ? row_cnt : r0;
    has_row = row_last || (row_cnt >= ROW_W'(2));
  end

  // configuration, position counters and pixel window
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w   <= WID_W'(RST_W);
      img_h   <= bb5_pkg::DIM_W'(bb5_pkg::RESET_HEIGHT);
      col_cnt <= '0;
      row_cnt <= '0;
      for (int k = 0; k < 4; k++) begin
        win[k] <= '0;
      end
    end else if (cfg_acc) begin
      case (cfg_index)
        bb5_pkg::REG_IMAGE_WIDTH: begin
          img_w   <= cfg_w;
          col_cnt <= '0;
          row_cnt <= '0;
        end
        bb5_pkg::REG_IMAGE_HEIGHT: begin
          img_h   <= cfg_h;
          col_cnt <= '0;
          row_cnt <= '0;
        end
        default: ;
      endcase
    end else if (in_acc) begin
      win[0] <= pix_in;
      for (int k = 1; k < 4; k++) begin
        win[k] <= (col_cnt == '0) ? pix_in : win[k-1];
      end
      if (!col_last) begin
        col_cnt <= col_cnt + COL_W'(1);
      end else begin
        col_cnt <= '0;
        row_cnt <= row_last ? '0 : row_cnt + ROW_W'(1);
      end
    end
  end

  // sequencer: walk finished rows, then columns within each row
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_acc) begin
      a_valid <= has_col;
      a_pix   <= p_new;
      a_x     <= col_cnt;
      a_y     <= row_cnt;
      a_c     <= c0;
      a_c0    <= c0;
      a_c1    <= c1;
      a_r     <= r0;
      a_r1    <= r1;
      a_emit  <= has_row;
      a_first <= 1'b1;
    end else if (pipe_en && a_valid) begin
      if (a_c != a_c1) begin
        a_c <= a_c + COL_W'(1);
      end else if (a_last) begin
        a_valid <= 1'b0;
      end else begin
        a_c     <= a_c0;
        a_r     <= a_r + ROW_W'(1);
        a_first <= 1'b0;
      end
    end
  end

  // horizontal sum of the current column from the clamped window
  always_comb begin
    logic [1:0] k;
    logic [2:0] idx;
    int         o;
    k    = 2'(a_x - a_c);
    a_hs = '0;
    for (int d = 0; d < 5; d++) begin
      o = int'(k) + 2 - d;
      if (o < 0) begin
        o = 0;
      end
      idx        = 3'(4 - o);
      a_hs.red   = a_hs.red   + bb5_pkg::HSUM_W'(a_pix[idx].red);
      a_hs.green = a_hs.green + bb5_pkg::HSUM_W'(a_pix[idx].green);
      a_hs.blue  = a_hs.blue  + bb5_pkg::HSUM_W'(a_pix[idx].blue);
    end
  end

  // advance to the memory read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pipe_en) begin
      b_valid <= a_valid;
      b_emit  <= a_emit;
      b_wr    <= a_first;
      b_last  <= a_last;
      b_hs    <= a_hs;
      b_r     <= a_r;
      b_y     <= a_y;
      b_c     <= a_c;
    end
  end

  bb5_sum_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .en     (pipe_en),
    .rd_addr(a_c),
    .wr_en  (wr_en),
    .wr_addr(b_c),
    .wr_data(wr_entry),
    .rd_data(rd_entry)
  );

  // write back this row's sum once per column, on the first row pass
  always_comb begin
    wr_en              = pipe_en && b_valid && b_wr;
    wr_entry           = rd_entry;
    wr_entry[b_y[1:0]] = b_hs;
  end

  // vertical sum over five clamped rows
  always_comb begin
    bb5_pkg::hsum_t h;
    int             rr;
    v_sum_r = '0;
    v_sum_g = '0;
    v_sum_b = '0;
    for (int d = 0; d < 5; d++) begin
      rr = int'(b_r) + d - 2;
      if (rr < 0) begin
        rr = 0;
      end
      if (rr >= int'(b_y)) begin
        h = b_hs;
      end else begin
        h = rd_entry[2'(rr)];
      end
      v_sum_r = v_sum_r + bb5_pkg::VSUM_W'(h.red);
      v_sum_g = v_sum_g + bb5_pkg::VSUM_W'(h.green);
      v_sum_b = v_sum_b + bb5_pkg::VSUM_W'(h.blue);
    end
  end

  // hold the sums for the divide
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (pipe_en) begin
      c_valid <= b_valid && b_emit;
      c_sum_r <= v_sum_r;
      c_sum_g <= v_sum_g;
      c_sum_b <= v_sum_b;
      c_col   <= bb5_pkg::COORD_W'(b_c);
      c_row   <= b_r;
      c_last  <= b_last;
    end
  end

  // rounded mean
  always_comb begin
    res.red   = bb5_pkg::div25(c_sum_r);
    res.green = bb5_pkg::div25(c_sum_g);
    res.blue  = bb5_pkg::div25(c_sum_b);
    res.col   = c_col;
    res.row   = c_row;
    res.last  = c_last;
  end

  // output register with skid; drain the skid first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        out_q      <= skid;
        skid_valid <= 1'b0;
      end
    end else if (c_valid) begin
      if (!out_valid || out_take) begin
        out_q     <= res;
        out_valid <= 1'b1;
      end else begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  assign blur_red    = out_q.red;
  assign blur_green  = out_q.green;
  assign blur_blue   = out_q.blue;
  assign out_col     = out_q.col;
  assign out_row     = out_q.row;
  assign last_of_run = out_q.last;

endmodule
